>>> rtl/crfbb_pkg.sv
package crfbb_pkg;

    localparam int MaxWidth   = 256;
    localparam int MaxHeight  = 256;
    localparam int FbDepth    = MaxWidth * MaxHeight;
    localparam int AddrW      = $clog2(FbDepth);
    localparam int XW         = $clog2(MaxWidth) + 1;
    localparam int YW         = $clog2(MaxHeight) + 1;

    // Commands
    localparam logic [1:0] CmdFill  = 2'd0;
    localparam logic [1:0] CmdCopy  = 2'd1;
    localparam logic [1:0] CmdPixel = 2'd2;
    localparam logic [1:0] CmdRead  = 2'd3;

    // Status codes
    localparam logic [1:0] StDone    = 2'd0;
    localparam logic [1:0] StOutside = 2'd1;
    localparam logic [1:0] StInvalid = 2'd2;

    // Register indexes
    localparam logic [1:0] RegWidth  = 2'd0;
    localparam logic [1:0] RegHeight = 2'd1;
    localparam logic [1:0] RegFormat = 2'd2;

    // Pixel formats
    localparam logic [2:0] FmtArgb32 = 3'd0;
    localparam logic [2:0] FmtRgb24  = 3'd1;
    localparam logic [2:0] FmtRgb555 = 3'd2;
    localparam logic [2:0] FmtRgb565 = 3'd3;
    localparam logic [2:0] FmtClut8  = 3'd4;

    // Truncating division by 255 for values up to 255*255.
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] q;
        begin
            q = ({1'b0, v} + 17'd1 + {9'd0, v[15:8]}) >> 8;
            div255 = q[7:0];
        end
    endfunction

endpackage

>>> rtl/clipped_rect_fill_blit_blend.sv
// Copy starts, stray or invisible pixels and rejected fills or reads load the result register
// from idle; a fill writes its visible pixels in S_FILL, a written source pixel is read, blended
// and written back in S_RMW_RD and S_RMW_WR, and an in-range read passes S_READ, then S_OUT.
// The input stalls while an item is in progress and while an untaken result is held. After reset
// the frame memory is cleared one word a cycle, with the input stalled, while configuration
// writes are taken.
module clipped_rect_fill_blit_blend
    import crfbb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic signed [9:0] i_rect_x,
    input  logic signed [9:0] i_rect_y,
    input  logic [8:0]  i_rect_width,
    input  logic [8:0]  i_rect_height,
    input  logic [31:0] i_pixel_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_read_data,
    output logic [1:0]  o_status,
    output logic        o_copy_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_FILL, S_RMW_RD, S_RMW_WR, S_READ, S_OUT
    } t_state;

    t_state r_state;

    // Frame memory
    logic [31:0] r_mem [FbDepth];
    logic [31:0] r_rdata;
    logic        mem_we;
    logic [AddrW-1:0] mem_waddr, mem_raddr;
    logic [31:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // Configuration
    logic [8:0] r_fb_w, r_fb_h;
    logic [2:0] r_fmt;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_w <= 9'd256;
            r_fb_h <= 9'd256;
            r_fmt  <= FmtArgb32;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegWidth:  r_fb_w <= i_cfg_data;
                RegHeight: r_fb_h <= i_cfg_data;
                RegFormat: r_fmt  <= i_cfg_data[2:0];
                default:   ;
            endcase
        end
    end

    // Effective sizes saturated to 1..MaxWidth and 1..MaxHeight
    logic [XW-1:0] eff_w;
    logic [YW-1:0] eff_h;
    always_comb begin
        if (r_fb_w == 9'd0) eff_w = XW'(1);
        else if ({2'b0, r_fb_w} > 11'(MaxWidth)) eff_w = XW'(MaxWidth);
        else eff_w = XW'(r_fb_w);
        if (r_fb_h == 9'd0) eff_h = YW'(1);
        else if ({2'b0, r_fb_h} > 11'(MaxHeight)) eff_h = YW'(MaxHeight);
        else eff_h = YW'(r_fb_h);
    end

    logic fmt_known;
    assign fmt_known = (r_fmt <= FmtClut8);

    logic [31:0] fmt_mask;
    always_comb begin
        if (r_fmt <= FmtRgb24) fmt_mask = 32'hFFFF_FFFF;
        else if (r_fmt <= FmtRgb565) fmt_mask = 32'h0000_FFFF;
        else fmt_mask = 32'h0000_00FF;
    end

    // Clipping of the incoming rectangle
    logic signed [11:0] sx, sy, sxr, syb, cxl, cyt, cxr, cyb;
    logic clip_vis;
    always_comb begin
        sx  = 12'(i_rect_x);
        sy  = 12'(i_rect_y);
        sxr = sx + $signed({3'b0, i_rect_width});
        syb = sy + $signed({3'b0, i_rect_height});
        cxl = (sx < 0) ? 12'sd0 : sx;
        cyt = (sy < 0) ? 12'sd0 : sy;
        cxr = (sxr >= $signed(12'(eff_w))) ? $signed(12'(eff_w)) : sxr;
        cyb = (syb >= $signed(12'(eff_h))) ? $signed(12'(eff_h)) : syb;
        clip_vis = (cxr > cxl) && (cyb > cyt);
    end

    // Address of (col,row) with row stride eff_w
    function automatic logic [AddrW-1:0] addr_of(input logic [XW-1:0] c,
                                                 input logic [YW-1:0] r,
                                                 input logic [XW-1:0] w);
        logic [XW+YW-1:0] p;
        begin
            p = XW'(r) * w + (XW+YW)'(c);
            addr_of = p[AddrW-1:0];
        end
    endfunction

    // Copy state
    logic signed [9:0] r_cox, r_coy;
    logic [8:0] r_cw, r_ch, r_ccol, r_crow;
    logic       r_cact;

    logic signed [11:0] px, py;
    logic pix_vis;
    assign px = 12'(r_cox) + $signed({3'b0, r_ccol});
    assign py = 12'(r_coy) + $signed({3'b0, r_crow});
    assign pix_vis = (px >= 0) && (px < $signed(12'(eff_w))) && (py >= 0)
                   && (py < $signed(12'(eff_h)));

    logic rd_vis;
    assign rd_vis = (i_rect_x >= 0) && ($signed(12'(i_rect_x)) < $signed(12'(eff_w)))
                  && (i_rect_y >= 0) && ($signed(12'(i_rect_y)) < $signed(12'(eff_h)));

    // Working registers
    logic [AddrW:0]   r_clr;
    logic [XW-1:0]    r_fc, r_fxl, r_fxr;
    logic [YW-1:0]    r_fr, r_fyb;
    logic [31:0]      r_val;
    logic [AddrW-1:0] r_addr;
    logic             r_do_blend;

    // Blend of the stored word with the held source pixel
    logic [31:0] blend_out;
    always_comb begin
        logic [7:0] sa, inv;
        sa  = r_val[31:24];
        inv = 8'hFF - sa;
        blend_out[31:24] = div255(16'(sa) * 16'hFF + 16'(r_rdata[31:24]) * 16'(inv));
        for (int k = 0; k < 3; k++) begin
            blend_out[k*8 +: 8] = div255(16'(r_val[k*8 +: 8]) * 16'(sa)
                                  + 16'(r_rdata[k*8 +: 8]) * 16'(inv));
        end
    end

    logic accept, out_free;
    assign out_free = !o_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || !out_free;
    assign accept   = i_valid && !o_stall;

    // Memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_of(r_fc, r_fr, eff_w);
        mem_wdata = r_val;
        mem_raddr = addr_of(XW'(i_rect_x[8:0]), YW'(i_rect_y[8:0]), eff_w);
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr[AddrW-1:0];
                mem_wdata = 32'd0;
            end
            S_FILL: mem_we = 1'b1;
            S_RMW_RD: mem_raddr = r_addr;
            S_RMW_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = r_do_blend ? blend_out : r_val;
            end
            default: ;
        endcase
        if (r_state == S_IDLE) begin
            mem_raddr = (i_command == CmdPixel)
                      ? addr_of(XW'(px[8:0]), YW'(py[8:0]), eff_w)
                      : addr_of(XW'(i_rect_x[8:0]), YW'(i_rect_y[8:0]), eff_w);
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cact      <= 1'b0;
            r_ccol      <= '0;
            r_crow      <= '0;
            o_valid     <= 1'b0;
            o_read_data <= '0;
            o_status    <= StDone;
            o_copy_last <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AddrW+1)'(FbDepth - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        o_read_data <= '0;
                        o_status    <= StDone;
                        o_copy_last <= 1'b0;
                        case (i_command)
                            CmdFill: begin
                                r_fc  <= XW'(cxl[8:0]);
                                r_fxl <= XW'(cxl[8:0]);
                                r_fr  <= YW'(cyt[8:0]);
                                r_fxr <= XW'(cxr[9:0]);
                                r_fyb <= YW'(cyb[9:0]);
                                r_val <= i_pixel_value & fmt_mask;
                                if (!clip_vis) begin
                                    o_status <= StOutside;
                                    o_valid  <= 1'b1;
                                end else if (!fmt_known) begin
                                    o_valid <= 1'b1;
                                end else begin
                                    r_state <= S_FILL;
                                end
                            end
                            CmdCopy: begin
                                o_valid <= 1'b1;
                                r_cact  <= 1'b0;
                                if (i_rect_width == 9'd0 || i_rect_height == 9'd0) begin
                                    o_status <= StOutside;
                                end else begin
                                    r_cox  <= i_rect_x;
                                    r_coy  <= i_rect_y;
                                    r_cw   <= i_rect_width;
                                    r_ch   <= i_rect_height;
                                    r_ccol <= '0;
                                    r_crow <= '0;
                                    r_cact <= 1'b1;
                                    if (!clip_vis) o_status <= StOutside;
                                end
                            end
                            CmdPixel: begin
                                if (!r_cact) begin
                                    o_status <= StInvalid;
                                    o_valid  <= 1'b1;
                                end else begin
                                    r_addr     <= addr_of(XW'(px[8:0]), YW'(py[8:0]), eff_w);
                                    r_val      <= i_pixel_value & fmt_mask;
                                    r_do_blend <= (r_fmt == FmtArgb32);
                                    if (pix_vis && fmt_known) begin
                                        r_state <= S_RMW_RD;
                                    end else begin
                                        o_valid <= 1'b1;
                                    end
                                    if (10'(r_ccol) + 10'd1 >= 10'(r_cw)) begin
                                        r_ccol <= '0;
                                        if (10'(r_crow) + 10'd1 >= 10'(r_ch)) begin
                                            r_crow      <= '0;
                                            r_cact      <= 1'b0;
                                            o_copy_last <= 1'b1;
                                        end else begin
                                            r_crow <= r_crow + 1'b1;
                                        end
                                    end else begin
                                        r_ccol <= r_ccol + 1'b1;
                                    end
                                end
                            end
                            default: begin
                                if (rd_vis) begin
                                    r_state <= S_READ;
                                end else begin
                                    o_status <= StInvalid;
                                    o_valid  <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_FILL: begin
                    if (r_fc + 1'b1 >= r_fxr) begin
                        r_fc <= r_fxl;
                        if (r_fr + 1'b1 >= r_fyb) begin
                            r_state <= S_OUT;
                        end else begin
                            r_fr <= r_fr + 1'b1;
                        end
                    end else begin
                        r_fc <= r_fc + 1'b1;
                    end
                end
                S_RMW_RD: r_state <= S_RMW_WR;
                S_RMW_WR: r_state <= S_OUT;
                S_READ: begin
                    o_read_data <= r_rdata;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // A source pixel marked as the end of a copy leaves no copy open.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CmdPixel && r_cact && 10'(r_ccol) + 10'd1 >= 10'(r_cw)
         && 10'(r_crow) + 10'd1 >= 10'(r_ch)) |=> !r_cact)
        else $error("copy still open after its last pixel");

    // No item is taken during the clear of the frame memory.
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !accept)
        else $error("item accepted during frame clear");

    // The memory is written only by the clear, a fill, or the write-back.
    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR || r_state == S_FILL || r_state == S_RMW_WR))
        else $error("memory written outside a writing state");

    // A held result does not change while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_read_data) && $stable(o_status)))
        else $error("result changed while stalled");
`endif

endmodule
